// ----- rtl/pfs_pkg.sv -----
// shared constants, codes and types of the primitive-to-face splitter
`timescale 1ns / 1ps

package pfs_pkg;

    // sizes
    localparam int MAX_FACES = 64;
    localparam int IDX_W     = 7;
    localparam int CNT_W     = 32;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 64;
    localparam logic [IDX_W-1:0] MAX_LEN = IDX_W'(MAX_FACES + 2);

    // command codes
    localparam logic OP_ASSEMBLE = 1'b0;
    localparam logic OP_REWIND   = 1'b1;

    // primitive type codes that produce faces
    localparam logic [3:0] PT_TRIANGLES = 4'd4;
    localparam logic [3:0] PT_TRISTRIP  = 4'd5;
    localparam logic [3:0] PT_FAN       = 4'd6;
    localparam logic [3:0] PT_QUADS     = 4'd7;
    localparam logic [3:0] PT_QUADSTRIP = 4'd8;
    localparam logic [3:0] PT_POLYGON   = 4'd9;

    // face layout kinds used by the sequencer and corner former
    localparam logic [2:0] KIND_TRI    = 3'd0;
    localparam logic [2:0] KIND_STRIP  = 3'd1;
    localparam logic [2:0] KIND_FAN    = 3'd2;
    localparam logic [2:0] KIND_QUAD   = 3'd3;
    localparam logic [2:0] KIND_QSTRIP = 3'd4;

    // one face request from the sequencer
    typedef struct packed {
        logic             load;
        logic             last;
        logic [2:0]       kind;
        logic [IDX_W-1:0] base;
        logic             odd;
    } t_face_ctl;

    // corners of one face
    typedef struct packed {
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
        logic [IDX_W-1:0] d;
        logic             quad;
    } t_face;

endpackage

// ----- rtl/pfs_corner.sv -----
// corner index former: turns a face base index and layout kind into four corners
`timescale 1ns / 1ps

module pfs_corner (
    input  pfs_pkg::t_face_ctl i_ctl,
    output pfs_pkg::t_face     o_face
);

    logic [pfs_pkg::IDX_W-1:0] w_p1;
    logic [pfs_pkg::IDX_W-1:0] w_p2;
    logic [pfs_pkg::IDX_W-1:0] w_p3;

    assign w_p1 = i_ctl.base + pfs_pkg::IDX_W'(1);
    assign w_p2 = i_ctl.base + pfs_pkg::IDX_W'(2);
    assign w_p3 = i_ctl.base + pfs_pkg::IDX_W'(3);

    // corner selection per layout
    always_comb begin
        o_face = '0;
        unique case (i_ctl.kind)
            pfs_pkg::KIND_TRI: begin
                o_face.a = i_ctl.base;
                o_face.b = w_p1;
                o_face.c = w_p2;
            end
            pfs_pkg::KIND_STRIP: begin
                // odd strip faces swap the first two corners to keep winding
                o_face.a = i_ctl.odd ? w_p1 : i_ctl.base;
                o_face.b = i_ctl.odd ? i_ctl.base : w_p1;
                o_face.c = w_p2;
            end
            pfs_pkg::KIND_FAN: begin
                o_face.a = '0;
                o_face.b = w_p1;
                o_face.c = w_p2;
            end
            pfs_pkg::KIND_QUAD: begin
                o_face.a    = i_ctl.base;
                o_face.b    = w_p1;
                o_face.c    = w_p2;
                o_face.d    = w_p3;
                o_face.quad = 1'b1;
            end
            pfs_pkg::KIND_QSTRIP: begin
                o_face.a    = i_ctl.base;
                o_face.b    = w_p1;
                o_face.c    = w_p3;
                o_face.d    = w_p2;
                o_face.quad = 1'b1;
            end
            default: begin
                o_face = '0;
            end
        endcase
    end

endmodule

// ----- rtl/pfs_seq.sv -----
// face sequencer: decodes a primitive header and steps the face base with one adder
`timescale 1ns / 1ps

module pfs_seq (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      i_opcode,
    input  logic [3:0]                i_type,
    input  logic [pfs_pkg::IDX_W-1:0] i_length,
    input  logic                      i_slot_free,
    output logic                      o_ready,
    output logic                      o_rewind,
    output pfs_pkg::t_face_ctl        o_ctl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EMIT = 1'b1;

    logic                      r_state;
    logic                      n_state;
    logic [2:0]                r_kind;
    logic [2:0]                r_step;
    logic [pfs_pkg::IDX_W-1:0] r_lim;
    logic [pfs_pkg::IDX_W-1:0] r_base;
    logic                      r_odd;

    logic                      w_accept;
    logic [pfs_pkg::IDX_W-1:0] w_len;
    logic                      w_known;
    logic [2:0]                w_kind;
    logic [2:0]                w_span;
    logic [2:0]                w_step;
    logic                      w_first_ok;
    logic                      w_load;
    logic [pfs_pkg::IDX_W-1:0] w_next_base;
    logic                      w_last;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign o_rewind = w_accept && (i_opcode == pfs_pkg::OP_REWIND);

    // clip the vertex count
    assign w_len = (i_length > pfs_pkg::MAX_LEN) ? pfs_pkg::MAX_LEN : i_length;

    // header decode: layout, top corner offset and base stride
    always_comb begin
        w_known = 1'b1;
        w_kind  = pfs_pkg::KIND_TRI;
        w_span  = 3'd2;
        w_step  = 3'd3;
        unique case (i_type)
            pfs_pkg::PT_TRIANGLES: begin
                w_kind = pfs_pkg::KIND_TRI;
                w_span = 3'd2;
                w_step = 3'd3;
            end
            pfs_pkg::PT_TRISTRIP: begin
                w_kind = pfs_pkg::KIND_STRIP;
                w_span = 3'd2;
                w_step = 3'd1;
            end
            pfs_pkg::PT_FAN: begin
                w_kind = pfs_pkg::KIND_FAN;
                w_span = 3'd2;
                w_step = 3'd1;
            end
            pfs_pkg::PT_QUADS: begin
                w_kind = pfs_pkg::KIND_QUAD;
                w_span = 3'd3;
                w_step = 3'd4;
            end
            pfs_pkg::PT_QUADSTRIP: begin
                w_kind = pfs_pkg::KIND_QSTRIP;
                w_span = 3'd3;
                w_step = 3'd2;
            end
            pfs_pkg::PT_POLYGON: begin
                // a four-vertex polygon is one quad, others are fans
                if (w_len == pfs_pkg::IDX_W'(4)) begin
                    w_kind = pfs_pkg::KIND_QUAD;
                    w_span = 3'd3;
                    w_step = 3'd4;
                end else begin
                    w_kind = pfs_pkg::KIND_FAN;
                    w_span = 3'd2;
                    w_step = 3'd1;
                end
            end
            default: begin
                w_known = 1'b0;
            end
        endcase
    end

    assign w_first_ok = w_known && (w_len > pfs_pkg::IDX_W'(w_span));

    // shared stride adder and end-of-primitive compare
    assign w_load      = (r_state == S_EMIT) && i_slot_free;
    assign w_next_base = r_base + pfs_pkg::IDX_W'(r_step);
    assign w_last      = (w_next_base >= r_lim);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_opcode == pfs_pkg::OP_ASSEMBLE) && w_first_ok) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_load && w_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // primitive registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_kind <= w_kind;
            r_step <= w_step;
            r_lim  <= w_len - pfs_pkg::IDX_W'(w_span);
            r_base <= '0;
            r_odd  <= 1'b0;
        end else if (w_load) begin
            r_base <= w_next_base;
            r_odd  <= ~r_odd;
        end
    end

    // face request to the corner former
    always_comb begin
        o_ctl.load = w_load;
        o_ctl.last = w_last;
        o_ctl.kind = r_kind;
        o_ctl.base = r_base;
        o_ctl.odd  = r_odd;
    end

endmodule

// ----- rtl/primitive_to_face_splitter.sv -----
// primitive-to-face splitter top level: sequencer, corner former, output register
//
//  channel  | dir | payload
//  ---------+-----+-----------------------------------------------------------
//  s (in)   | in  | tdata: prim_type, prim_length; tuser: opcode
//  m (out)  | out | tdata: corner_a..corner_d, face_number; tuser: is_quad;
//           |     | tlast: last_face
//
// a primitive header is accepted first, and then one face is produced per cycle
// while the output slot is free; the single stride adder of the sequencer sets
// this one-face-per-cycle pace. a rewind or a header that yields no face
// leaves the sequencer ready for the next header.
// input is not ready while faces of a header are still being produced.
// a stall on the output holds the sequencer on the current face.
// reset is synchronous, active low, and clears the face number.
`timescale 1ns / 1ps

module primitive_to_face_splitter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // [3:0] prim_type, [10:4] prim_length, [15:11] zero
    input  logic [pfs_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [0] opcode
    input  logic [0:0]                    i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // [6:0] corner_a, [13:7] corner_b, [20:14] corner_c, [27:21] corner_d,
    // [59:28] face_number, [63:60] zero
    output logic [pfs_pkg::M_TDATA_W-1:0] o_m_tdata,
    // [0] is_quad
    output logic [0:0]                    o_m_tuser,
    output logic                          o_m_tlast
);

    logic                      w_slot_free;
    logic                      w_rewind;
    pfs_pkg::t_face_ctl        w_ctl;
    pfs_pkg::t_face            w_face;

    logic                      r_m_valid;
    pfs_pkg::t_face            r_m_face;
    logic [pfs_pkg::CNT_W-1:0] r_m_num;
    logic                      r_m_last;
    logic [pfs_pkg::CNT_W-1:0] r_face_cnt;

    assign w_slot_free = !r_m_valid || i_m_tready;

    pfs_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .i_opcode    (i_s_tuser[0]),
        .i_type      (i_s_tdata[3:0]),
        .i_length    (i_s_tdata[10:4]),
        .i_slot_free (w_slot_free),
        .o_ready     (o_s_tready),
        .o_rewind    (w_rewind),
        .o_ctl       (w_ctl)
    );

    pfs_corner u_corner (
        .i_ctl  (w_ctl),
        .o_face (w_face)
    );

    // running face number
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_face_cnt <= '0;
        end else if (w_rewind) begin
            r_face_cnt <= '0;
        end else if (w_ctl.load) begin
            r_face_cnt <= r_face_cnt + pfs_pkg::CNT_W'(1);
        end
    end

    // output beat valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_ctl.load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    // output beat payload
    always_ff @(posedge i_clk) begin
        if (w_ctl.load) begin
            r_m_face <= w_face;
            r_m_num  <= r_face_cnt;
            r_m_last <= w_ctl.last;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {4'b0000, r_m_num, r_m_face.d, r_m_face.c, r_m_face.b, r_m_face.a};
    assign o_m_tuser  = r_m_face.quad;
    assign o_m_tlast  = r_m_last;

    // face number steps by one for each face loaded
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.load |=> r_face_cnt == $past(r_face_cnt) + pfs_pkg::CNT_W'(1))
        else $error("face number did not advance on a face load");

    // no new header is taken while faces are being produced
    a_busy_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.load && !w_ctl.last) |=> !o_s_tready)
        else $error("input ready in the middle of a primitive");

    // the final face returns the sequencer to accepting headers
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.load && w_ctl.last) |=> o_s_tready)
        else $error("sequencer still busy after the final face");

    // a rewind never coincides with a face load
    a_rewind_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rewind |-> !w_ctl.load)
        else $error("rewind taken while a face was loading");

endmodule

// ----- sim/primitive_to_face_splitter_test.sv -----
// self-checking testbench of the primitive-to-face splitter with a face scoreboard
`timescale 1ns / 1ps

module primitive_to_face_splitter_test;

    // primitive codes that never yield faces
    localparam logic [3:0] PT_POINTS     = 4'd0;
    localparam logic [3:0] PT_LINES      = 4'd1;
    localparam logic [3:0] PT_LINE_LOOP  = 4'd2;
    localparam logic [3:0] PT_LINE_STRIP = 4'd3;
    localparam logic [3:0] PT_UNKNOWN    = 4'd15;

    localparam int N_RANDOM     = 345;
    localparam int STEADY_FIRST = 150;
    localparam int STEADY_LAST  = 230;

    // one expected face
    typedef struct packed {
        pfs_pkg::t_face            corners;
        logic [pfs_pkg::CNT_W-1:0] number;
        logic                      is_last;
    } t_face_due;

    class face_scoreboard;
        t_face_due                 faces_due[$];
        logic [pfs_pkg::CNT_W-1:0] next_number = '0;
        int                        errors      = 0;
        int                        faces_seen  = 0;
        int                        headers     = 0;
        int                        rewinds     = 0;

        task report(string msg);
            errors++;
            $display("%0t ns  mismatch: %s", $time, msg);
        endtask

        // accepted header beat: split the primitive into its expected faces
        function void split_primitive(logic op, logic [3:0] ptype,
                                      logic [pfs_pkg::IDX_W-1:0] plen);
            int        len;
            int        count;
            bit        quad;
            t_face_due f;
            if (op == pfs_pkg::OP_REWIND) begin
                next_number = '0;
                rewinds++;
                return;
            end
            headers++;
            len   = (plen > pfs_pkg::MAX_LEN) ? int'(pfs_pkg::MAX_LEN) : int'(plen);
            count = 0;
            quad  = 1'b0;
            case (ptype) inside
                pfs_pkg::PT_TRIANGLES: count = len / 3;
                pfs_pkg::PT_TRISTRIP, pfs_pkg::PT_FAN: begin
                    if (len >= 3) count = len - 2;
                end
                pfs_pkg::PT_QUADS: begin
                    count = len / 4;
                    quad  = 1'b1;
                end
                pfs_pkg::PT_QUADSTRIP: begin
                    if (len >= 4) count = (len - 2) / 2;
                    quad = 1'b1;
                end
                pfs_pkg::PT_POLYGON: begin
                    if (len == 4) begin
                        count = 1;
                        quad  = 1'b1;
                    end else if (len >= 3) begin
                        count = len - 2;
                    end
                end
                default: count = 0;
            endcase
            if (count > pfs_pkg::MAX_FACES) count = pfs_pkg::MAX_FACES;
            for (int k = 0; k < count; k++) begin
                f = '0;
                case (ptype)
                    pfs_pkg::PT_TRIANGLES: begin
                        f.corners.a = pfs_pkg::IDX_W'(3 * k);
                        f.corners.b = pfs_pkg::IDX_W'(3 * k + 1);
                        f.corners.c = pfs_pkg::IDX_W'(3 * k + 2);
                    end
                    pfs_pkg::PT_TRISTRIP: begin
                        // winding flips on every odd face
                        f.corners.a = pfs_pkg::IDX_W'((k % 2 != 0) ? k + 1 : k);
                        f.corners.b = pfs_pkg::IDX_W'((k % 2 != 0) ? k : k + 1);
                        f.corners.c = pfs_pkg::IDX_W'(k + 2);
                    end
                    pfs_pkg::PT_QUADS: begin
                        f.corners.a = pfs_pkg::IDX_W'(4 * k);
                        f.corners.b = pfs_pkg::IDX_W'(4 * k + 1);
                        f.corners.c = pfs_pkg::IDX_W'(4 * k + 2);
                        f.corners.d = pfs_pkg::IDX_W'(4 * k + 3);
                    end
                    pfs_pkg::PT_QUADSTRIP: begin
                        f.corners.a = pfs_pkg::IDX_W'(2 * k);
                        f.corners.b = pfs_pkg::IDX_W'(2 * k + 1);
                        f.corners.c = pfs_pkg::IDX_W'(2 * k + 3);
                        f.corners.d = pfs_pkg::IDX_W'(2 * k + 2);
                    end
                    default: begin
                        // fan and polygon; a four-vertex polygon is one quad
                        f.corners.a = '0;
                        f.corners.b = pfs_pkg::IDX_W'(quad ? 1 : k + 1);
                        f.corners.c = pfs_pkg::IDX_W'(quad ? 2 : k + 2);
                        f.corners.d = pfs_pkg::IDX_W'(quad ? 3 : 0);
                    end
                endcase
                f.corners.quad = quad;
                f.number       = next_number;
                f.is_last      = (k == count - 1);
                faces_due.push_back(f);
                next_number++;
            end
        endfunction

        task compare(string field, longint unsigned got, longint unsigned want);
            if (got != want) begin
                report($sformatf("face %0d %s: got %0d, expected %0d",
                                 faces_seen, field, got, want));
            end
        endtask

        // accepted face beat: compare with the oldest expected face
        task check_face(logic [pfs_pkg::M_TDATA_W-1:0] data, logic [0:0] user,
                        logic lastbit);
            t_face_due f;
            if (faces_due.size() == 0) begin
                report($sformatf("face with no expectation, tdata %h", data));
                return;
            end
            f = faces_due.pop_front();
            compare("corner_a", data[6:0], f.corners.a);
            compare("corner_b", data[13:7], f.corners.b);
            compare("corner_c", data[20:14], f.corners.c);
            compare("corner_d", data[27:21], f.corners.d);
            compare("face_number", data[59:28], f.number);
            compare("pad bits", data[63:60], 0);
            compare("is_quad", user[0], f.corners.quad);
            compare("last_face", lastbit, f.is_last);
            faces_seen++;
        endtask
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_s_tvalid;
    logic                          o_s_tready;
    logic [pfs_pkg::S_TDATA_W-1:0] i_s_tdata;
    logic [0:0]                    i_s_tuser;
    logic                          o_m_tvalid;
    logic                          i_m_tready;
    logic [pfs_pkg::M_TDATA_W-1:0] o_m_tdata;
    logic [0:0]                    o_m_tuser;
    logic                          o_m_tlast;
    logic                          steady;

    face_scoreboard sb = new();

    primitive_to_face_splitter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #10 i_clk = ~i_clk;

    // face sink with random stalls
    always @(posedge i_clk) begin
        i_m_tready <= steady || ($urandom_range(99) >= 32);
    end

    // beat monitors on both channels
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_face(o_m_tdata, o_m_tuser, o_m_tlast);
        end
        if (i_rst_n && i_s_tvalid && o_s_tready) begin
            sb.split_primitive(i_s_tuser[0], i_s_tdata[3:0], i_s_tdata[10:4]);
        end
    end

    // present one header beat and hold it until taken
    task automatic send_header(logic op, logic [3:0] ptype,
                               logic [pfs_pkg::IDX_W-1:0] plen);
        if (!steady) begin
            while ($urandom_range(99) < 32) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= op;
        i_s_tdata  <= {5'b0, plen, ptype};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // mostly face-producing headers of small size, some long, some noise
    task automatic send_random_header();
        int                        r;
        int                        s;
        logic [3:0]                ptype;
        logic [pfs_pkg::IDX_W-1:0] plen;
        r = $urandom_range(99);
        s = $urandom_range(99);
        if (s < 70) begin
            plen = pfs_pkg::IDX_W'($urandom_range(12));
        end else if (s < 90) begin
            plen = pfs_pkg::IDX_W'($urandom_range(66, 13));
        end else begin
            plen = pfs_pkg::IDX_W'($urandom_range(127, 67));
        end
        if (r < 6) begin
            send_header(pfs_pkg::OP_REWIND, 4'($urandom_range(15)),
                        pfs_pkg::IDX_W'($urandom_range(127)));
        end else if (r < 14) begin
            if ($urandom_range(1) == 0) begin
                ptype = PT_POINTS + 4'($urandom_range(3));
            end else begin
                ptype = pfs_pkg::PT_POLYGON + 4'($urandom_range(6, 1));
            end
            send_header(pfs_pkg::OP_ASSEMBLE, ptype, pfs_pkg::IDX_W'($urandom_range(127)));
        end else begin
            ptype = pfs_pkg::PT_TRIANGLES + 4'($urandom_range(5));
            send_header(pfs_pkg::OP_ASSEMBLE, ptype, plen);
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= pfs_pkg::OP_ASSEMBLE;
        i_m_tready <= 1'b0;
        steady     <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: every type, short, tail, clipped and rewind cases
        send_header(pfs_pkg::OP_REWIND, PT_UNKNOWN, 7'd127);
        send_header(pfs_pkg::OP_ASSEMBLE, PT_POINTS, 7'd10);
        send_header(pfs_pkg::OP_ASSEMBLE, PT_LINES, 7'd8);
        send_header(pfs_pkg::OP_ASSEMBLE, PT_LINE_LOOP, 7'd5);
        send_header(pfs_pkg::OP_ASSEMBLE, PT_LINE_STRIP, 7'd6);
        send_header(pfs_pkg::OP_ASSEMBLE, PT_UNKNOWN, 7'd20);
        send_header(pfs_pkg::OP_ASSEMBLE, pfs_pkg::PT_TRIANGLES, 7'd2);
        send_header(pfs_pkg::OP_ASSEMBLE, pfs_pkg::PT_TRIANGLES, 7'd3);
        send_header(pfs_pkg::OP_ASSEMBLE, pfs_pkg::PT_TRIANGLES, 7'd8);
        send_header(pfs_pkg::OP_ASSEMBLE, pfs_pkg::PT_TRISTRIP, 7'd7);
        send_header(pfs_pkg::OP_ASSEMBLE, pfs_pkg::PT_FAN, 7'd5);
        send_header(pfs_pkg::OP_ASSEMBLE, pfs_pkg::PT_QUADS, 7'd3);
        send_header(pfs_pkg::OP_ASSEMBLE, pfs_pkg::PT_QUADS, 7'd11);
        send_header(pfs_pkg::OP_ASSEMBLE, pfs_pkg::PT_QUADSTRIP, 7'd3);
        send_header(pfs_pkg::OP_ASSEMBLE, pfs_pkg::PT_QUADSTRIP, 7'd9);
        send_header(pfs_pkg::OP_ASSEMBLE, pfs_pkg::PT_POLYGON, 7'd4);
        send_header(pfs_pkg::OP_ASSEMBLE, pfs_pkg::PT_POLYGON, 7'd5);
        send_header(pfs_pkg::OP_ASSEMBLE, pfs_pkg::PT_POLYGON, 7'd2);
        send_header(pfs_pkg::OP_REWIND, PT_POINTS, 7'd0);
        send_header(pfs_pkg::OP_ASSEMBLE, pfs_pkg::PT_TRISTRIP, 7'd66);
        send_header(pfs_pkg::OP_ASSEMBLE, pfs_pkg::PT_FAN, 7'd127);
        send_header(pfs_pkg::OP_ASSEMBLE, pfs_pkg::PT_TRIANGLES, 7'd127);
        send_header(pfs_pkg::OP_ASSEMBLE, pfs_pkg::PT_QUADSTRIP, 7'd0);
        send_header(pfs_pkg::OP_ASSEMBLE, pfs_pkg::PT_POLYGON, 7'd3);
        send_header(pfs_pkg::OP_ASSEMBLE, pfs_pkg::PT_QUADS, 7'd64);

        // random part with one stretch free of idling on both sides
        for (int n = 0; n < N_RANDOM; n++) begin
            steady <= (n >= STEADY_FIRST) && (n < STEADY_LAST);
            send_random_header();
        end
        i_s_tvalid <= 1'b0;

        // drain, then let any stray face show up
        while (sb.faces_due.size() != 0) @(posedge i_clk);
        repeat (3 * pfs_pkg::MAX_FACES) @(posedge i_clk);

        $display("covered %0d primitive headers and %0d rewinds",
                 sb.headers, sb.rewinds);
        $display("%0d faces checked, %0d mismatches", sb.faces_seen, sb.errors);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("timeout with %0d faces still expected", sb.faces_due.size());
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
